>>> rtl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: %m");

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/swfr_pkg.sv
// Shared types and constants of the sync-word frame receiver.
package swfr_pkg;

    // Sync bytes: first byte, may repeat, then the second byte
    localparam logic [7:0] SYNC_FIRST  = 8'h13;
    localparam logic [7:0] SYNC_SECOND = 8'hAC;

    // Frame layout
    localparam int                LEN_WORD_IDX    = 4;
    localparam logic [14:0]       FRAME_TAIL      = 15'd5;
    localparam logic [14:0]       FRAME_WORDS_MAX = 15'd32767;

    // Configuration register file
    localparam int          APB_AW            = 3;
    localparam logic [0:0]  REG_MAX_PAYLOAD   = 1'b0;
    localparam logic [14:0] MAX_PAYLOAD_RESET = 15'd256;

    // Result status codes
    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_STORED     = 3'd1,
        ST_ACCEPTED   = 3'd2,
        ST_BAD_SUM    = 3'd3,
        ST_BAD_LEN    = 3'd4,
        ST_RING_FULL  = 3'd5,
        ST_LIST_FULL  = 3'd6
    } status_t;

    // Per-byte outcome flags passed from the frame core to the top level
    typedef struct packed {
        status_t status;
        logic    word_write;
        logic    msg_commit;
    } step_flags_t;

endpackage

>>> rtl/swfr_if.sv
// Valid/ready channels of the receiver: byte requests in, per-byte results out.
interface swfr_rx_if #(
    parameter int RING_DEPTH = 512,
    parameter int LIST_DEPTH = 32
);
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int LIST_AW = $clog2(LIST_DEPTH);

    logic               valid;
    logic               ready;
    logic [7:0]         rx_byte;
    logic [RING_AW-1:0] ring_read_ptr;
    logic [LIST_AW-1:0] list_read_ptr;

    modport source (output valid, rx_byte, ring_read_ptr, list_read_ptr, input ready);
    modport sink   (input valid, rx_byte, ring_read_ptr, list_read_ptr, output ready);
endinterface

interface swfr_result_if #(
    parameter int RING_DEPTH = 512,
    parameter int LIST_DEPTH = 32
);
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int LIST_AW = $clog2(LIST_DEPTH);

    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic               word_write;
    logic [RING_AW-1:0] word_addr;
    logic [15:0]        word_data;
    logic               msg_commit;
    logic [LIST_AW-1:0] msg_slot;
    logic [RING_AW-1:0] msg_start;
    logic [RING_AW-1:0] ring_commit_ptr;

    modport source (output valid, status, word_write, word_addr, word_data, msg_commit,
                    msg_slot, msg_start, ring_commit_ptr, input ready);
    modport sink   (input valid, status, word_write, word_addr, word_data, msg_commit,
                    msg_slot, msg_start, ring_commit_ptr, output ready);
endinterface

>>> rtl/swfr_frame_core.sv
// Frame state machine: sync hunt, word assembly, length and checksum checks, commit.
`include "assert_macros.svh"

module swfr_frame_core
    import swfr_pkg::*;
#(
    parameter int RING_DEPTH = 512,
    parameter int LIST_DEPTH = 32,
    localparam int RING_AW = $clog2(RING_DEPTH),
    localparam int LIST_AW = $clog2(LIST_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  logic [RING_AW-1:0] ring_read_ptr,
    input  logic [LIST_AW-1:0] list_read_ptr,
    input  logic [14:0]        max_payload,
    output step_flags_t        flags,
    output logic [RING_AW-1:0] word_addr,
    output logic [15:0]        word_data,
    output logic [LIST_AW-1:0] msg_slot,
    output logic [RING_AW-1:0] msg_start,
    output logic [RING_AW-1:0] ring_commit_ptr
);

    typedef enum logic [3:0] {
        PH_HUNT1 = 4'b0001,
        PH_HUNT2 = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_HIGH  = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         low_byte_reg, low_byte_next;
    logic [15:0]        sum_low_reg, sum_low_next;
    // only the low byte of the high-byte sum reaches the 16-bit check
    logic [7:0]         sum_high_reg, sum_high_next;
    logic [RING_AW-1:0] write_pos_reg, write_pos_next;
    logic [RING_AW-1:0] committed_pos_reg, committed_pos_next;
    logic [14:0]        word_count_reg, word_count_next;
    logic [14:0]        frame_words_reg, frame_words_next;
    logic [LIST_AW-1:0] list_pos_reg, list_pos_next;

    logic [RING_AW-1:0] ring_next_pos;
    logic [LIST_AW-1:0] list_next_pos;
    logic [15:0]        word;
    logic [7:0]         sum_high_upd;
    logic [15:0]        frame_sum;
    logic               is_len_word;
    logic               is_close_word;

    // Wrap-around successors of the ring and list write positions
    assign ring_next_pos = (write_pos_reg == RING_AW'(RING_DEPTH - 1)) ? '0
                         : write_pos_reg + 1'b1;
    assign list_next_pos = (list_pos_reg == LIST_AW'(LIST_DEPTH - 1)) ? '0
                         : list_pos_reg + 1'b1;

    assign word          = {rx_byte, low_byte_reg};
    assign sum_high_upd  = sum_high_reg + rx_byte;
    assign frame_sum     = sum_low_reg + {sum_high_upd, 8'h00};
    assign is_len_word   = (word_count_reg == 15'(LEN_WORD_IDX));
    assign is_close_word = (word_count_reg > 15'(LEN_WORD_IDX))
                        && (word_count_reg == frame_words_reg);

    // Next state and per-byte outcome
    always_comb
    begin
        phase_next         = phase_reg;
        low_byte_next      = low_byte_reg;
        sum_low_next       = sum_low_reg;
        sum_high_next      = sum_high_reg;
        write_pos_next     = write_pos_reg;
        committed_pos_next = committed_pos_reg;
        word_count_next    = word_count_reg;
        frame_words_next   = frame_words_reg;
        list_pos_next      = list_pos_reg;
        flags              = '{status: ST_IDLE, word_write: 1'b0, msg_commit: 1'b0};
        word_addr          = '0;
        word_data          = '0;
        msg_slot           = '0;
        msg_start          = '0;

        unique case (phase_reg)
            PH_HUNT1:
            begin
                if (rx_byte == SYNC_FIRST)
                begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    phase_next       = PH_LOW;
                    sum_low_next     = 16'(SYNC_FIRST);
                    sum_high_next    = SYNC_SECOND;
                    write_pos_next   = committed_pos_reg;
                    word_count_next  = '0;
                    frame_words_next = FRAME_WORDS_MAX;
                end
                else if (rx_byte != SYNC_FIRST)
                begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_LOW:
            begin
                low_byte_next = rx_byte;
                sum_low_next  = sum_low_reg + 16'(rx_byte);
                phase_next    = PH_HIGH;
            end
            PH_HIGH:
            begin
                if (ring_next_pos == ring_read_ptr)
                begin
                    // no room for another word, drop the frame
                    phase_next   = PH_HUNT1;
                    flags.status = ST_RING_FULL;
                end
                else if (is_len_word && (word > {1'b0, max_payload}))
                begin
                    sum_high_next = sum_high_upd;
                    phase_next    = PH_HUNT1;
                    flags.status  = ST_BAD_LEN;
                end
                else if (is_close_word)
                begin
                    sum_high_next = sum_high_upd;
                    phase_next    = PH_HUNT1;
                    if (list_next_pos == list_read_ptr)
                    begin
                        write_pos_next = committed_pos_reg;
                        flags.status   = ST_LIST_FULL;
                    end
                    else if (frame_sum == 16'h0000)
                    begin
                        flags.msg_commit   = 1'b1;
                        msg_slot           = list_pos_reg;
                        msg_start          = committed_pos_reg;
                        committed_pos_next = write_pos_reg;
                        list_pos_next      = list_next_pos;
                        flags.status       = ST_ACCEPTED;
                    end
                    else
                    begin
                        flags.status = ST_BAD_SUM;
                    end
                end
                else
                begin
                    // ordinary word: store it and advance
                    sum_high_next = sum_high_upd;
                    if (is_len_word)
                    begin
                        frame_words_next = word[15:1] + FRAME_TAIL;
                    end
                    flags.word_write = 1'b1;
                    word_addr        = write_pos_reg;
                    word_data        = word;
                    write_pos_next   = ring_next_pos;
                    word_count_next  = word_count_reg + 1'b1;
                    phase_next       = PH_LOW;
                    flags.status     = ST_STORED;
                end
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    assign ring_commit_ptr = committed_pos_next;

    // State registers, updated once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT1;
            low_byte_reg      <= '0;
            sum_low_reg       <= '0;
            sum_high_reg      <= '0;
            write_pos_reg     <= '0;
            committed_pos_reg <= '0;
            word_count_reg    <= '0;
            frame_words_reg   <= FRAME_WORDS_MAX;
            list_pos_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            low_byte_reg      <= low_byte_next;
            sum_low_reg       <= sum_low_next;
            sum_high_reg      <= sum_high_next;
            write_pos_reg     <= write_pos_next;
            committed_pos_reg <= committed_pos_next;
            word_count_reg    <= word_count_next;
            frame_words_reg   <= frame_words_next;
            list_pos_reg      <= list_pos_next;
        end
    end

    // A byte never both stores a word and commits a message
    `ASSERT_ALWAYS(a_store_xor_commit, clk, rst_n, !(flags.word_write && flags.msg_commit))
    // A commit always ends the frame
    `ASSERT_NEXT(a_commit_ends_frame, clk, rst_n, step && flags.msg_commit, phase_reg == PH_HUNT1)
    // The committed pointer moves only on a commit
    `ASSERT_IMPLIES(a_commit_ptr_moves, clk, rst_n, committed_pos_reg != $past(committed_pos_reg), $past(step && flags.msg_commit))
    // Inside a frame the word count never passes the closing word
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, (phase_reg == PH_LOW) || (phase_reg == PH_HIGH), word_count_reg <= frame_words_reg)

endmodule

>>> rtl/sync_word_frame_receiver.sv
// Top level of the sync-word frame receiver: APB register, input and result registers.
//
//  channel   dir   carries                                    handshake
//  rx        in    rx_byte, ring_read_ptr, list_read_ptr      valid/ready
//  result    out   status, word and commit fields, commit ptr valid/ready
//  apb       in    max_payload_bytes at byte address 0        psel/penable, pready=1
//
//  One byte per cycle sustained while results are taken; an accepted byte waits in
//  the input register, passes the frame state update, and its result is offered
//  from the result register.
//  The frame state update is combinational logic between the two registers.
//  Reset: frame hunt restarts, ring and list pointers at 0, max payload 256.
//  A stalled result holds; one more byte may wait in the input register, then
//  rx.ready drops until the result is taken.
module sync_word_frame_receiver
    import swfr_pkg::*;
#(
    parameter int RING_DEPTH = 512,
    parameter int LIST_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    swfr_rx_if.sink           rx,
    swfr_result_if.source     result
);

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int LIST_AW = $clog2(LIST_DEPTH);

    logic [14:0]        max_payload_reg;
    logic               cfg_write;

    logic               in_valid_reg;
    logic [7:0]         rx_byte_reg;
    logic [RING_AW-1:0] ring_read_ptr_reg;
    logic [LIST_AW-1:0] list_read_ptr_reg;
    logic               advance;

    step_flags_t        flags;
    logic [RING_AW-1:0] word_addr;
    logic [15:0]        word_data;
    logic [LIST_AW-1:0] msg_slot;
    logic [RING_AW-1:0] msg_start;
    logic [RING_AW-1:0] ring_commit_ptr;

    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic               word_write_reg;
    logic [RING_AW-1:0] word_addr_reg;
    logic [15:0]        word_data_reg;
    logic               msg_commit_reg;
    logic [LIST_AW-1:0] msg_slot_reg;
    logic [RING_AW-1:0] msg_start_reg;
    logic [RING_AW-1:0] ring_commit_ptr_reg;

    // APB register write and read-back
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == REG_MAX_PAYLOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            max_payload_reg <= pwdata[14:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_PAYLOAD: prdata = {17'd0, max_payload_reg};
            default:         prdata = '0;
        endcase
    end

    // Pipeline flow: the input register drains whenever the result slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            rx_byte_reg       <= rx.rx_byte;
            ring_read_ptr_reg <= rx.ring_read_ptr;
            list_read_ptr_reg <= rx.list_read_ptr;
        end
    end

    // Frame logic and state
    swfr_frame_core #(
        .RING_DEPTH (RING_DEPTH),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .rx_byte         (rx_byte_reg),
        .ring_read_ptr   (ring_read_ptr_reg),
        .list_read_ptr   (list_read_ptr_reg),
        .max_payload     (max_payload_reg),
        .flags           (flags),
        .word_addr       (word_addr),
        .word_data       (word_data),
        .msg_slot        (msg_slot),
        .msg_start       (msg_start),
        .ring_commit_ptr (ring_commit_ptr)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg          <= flags.status;
            word_write_reg      <= flags.word_write;
            word_addr_reg       <= word_addr;
            word_data_reg       <= word_data;
            msg_commit_reg      <= flags.msg_commit;
            msg_slot_reg        <= msg_slot;
            msg_start_reg       <= msg_start;
            ring_commit_ptr_reg <= ring_commit_ptr;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.status          = status_reg;
    assign result.word_write      = word_write_reg;
    assign result.word_addr       = word_addr_reg;
    assign result.word_data       = word_data_reg;
    assign result.msg_commit      = msg_commit_reg;
    assign result.msg_slot        = msg_slot_reg;
    assign result.msg_start       = msg_start_reg;
    assign result.ring_commit_ptr = ring_commit_ptr_reg;

endmodule
